// ----- hw/rtl/qrs_pkg.sv -----
`default_nettype none
package qrs_pkg;

  localparam int OUT_WIDTH = 33;

  typedef enum logic [1:0] {
    STATUS_REAL    = 2'd0,
    STATUS_COMPLEX = 2'd1,
    STATUS_DEGEN   = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/qrs_disc.sv -----
`default_nettype none
// Two stages: products, then discriminant and status.
module qrs_disc import qrs_pkg::*; #(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [CW-1:0] a_in,
  input  wire logic signed [CW-1:0] b_in,
  input  wire logic signed [CW-1:0] c_in,
  output logic                      out_valid,
  output logic [2*CW:0]             d_out,
  output status_t                   status_out,
  output logic signed [CW-1:0]      a_out,
  output logic signed [CW-1:0]      b_out
);

  localparam int DFW = 2 * CW + 3;

  logic                   v1;
  logic signed [CW-1:0]   a1;
  logic signed [CW-1:0]   b1;
  logic signed [2*CW-1:0] bb1;
  logic signed [2*CW-1:0] ac1;
  logic signed [DFW-1:0]  d_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= a_in;
      b1  <= b_in;
      bb1 <= (2 * CW)'(b_in) * (2 * CW)'(b_in);
      ac1 <= (2 * CW)'(a_in) * (2 * CW)'(c_in);
    end
  end

  assign d_full = DFW'(bb1) - (DFW'(ac1) <<< 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_out <= a1;
      b_out <= b1;
      priority if (a1 == '0) begin
        status_out <= STATUS_DEGEN;
        d_out      <= '0;
      end else if (d_full[DFW-1]) begin
        status_out <= STATUS_COMPLEX;
        d_out      <= '0;
      end else begin
        status_out <= STATUS_REAL;
        d_out      <= d_full[2*CW:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/qrs_sqrt.sv -----
`default_nettype none
// Digit-by-digit integer square root, one root bit per stage.
module qrs_sqrt #(
  parameter int NW     = 66,
  parameter int SIDE_W = 34
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NW-1:0]     rad_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [NW/2-1:0]        root_out,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int SW = NW / 2;
  localparam int RW = SW + 3;

  logic              vld_q  [1:SW];
  logic [NW-1:0]     rad_q  [1:SW];
  logic [RW-1:0]     rem_q  [1:SW];
  logic [SW-1:0]     root_q [1:SW];
  logic [SIDE_W-1:0] side_q [1:SW];

  for (genvar k = 1; k <= SW; k++) begin : g_stage
    logic              v_src;
    logic [NW-1:0]     rad_src;
    logic [RW-1:0]     rem_src;
    logic [SW-1:0]     root_src;
    logic [SIDE_W-1:0] side_src;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic              take;

    if (k == 1) begin : g_first
      assign v_src    = in_valid;
      assign rad_src  = rad_in;
      assign rem_src  = '0;
      assign root_src = '0;
      assign side_src = side_in;
    end else begin : g_rest
      assign v_src    = vld_q[k-1];
      assign rad_src  = rad_q[k-1];
      assign rem_src  = rem_q[k-1];
      assign root_src = root_q[k-1];
      assign side_src = side_q[k-1];
    end

    assign rem_sh = {rem_src[RW-3:0], rad_src[NW-1 -: 2]};
    assign trial  = {1'b0, root_src, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= rad_src << 2;
        rem_q[k]  <= take ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_src[SW-2:0], take};
        side_q[k] <= side_src;
      end
    end
  end

  assign out_valid = vld_q[SW];
  assign root_out  = root_q[SW];
  assign side_out  = side_q[SW];

endmodule
`default_nettype wire

// ----- hw/rtl/qrs_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per stage, two numerators over one divisor.
module qrs_div #(
  parameter int NUMW   = 34,
  parameter int DENW   = 17,
  parameter int SIDE_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUMW-1:0]   num_p_in,
  input  wire logic [NUMW-1:0]   num_m_in,
  input  wire logic [DENW-1:0]   den_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [NUMW-1:0]        quo_p_out,
  output logic [NUMW-1:0]        quo_m_out,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int RW = DENW + 1;

  logic              vld_q  [1:NUMW];
  logic [NUMW-1:0]   np_q   [1:NUMW];
  logic [NUMW-1:0]   nm_q   [1:NUMW];
  logic [RW-1:0]     rp_q   [1:NUMW];
  logic [RW-1:0]     rm_q   [1:NUMW];
  logic [NUMW-1:0]   qp_q   [1:NUMW];
  logic [NUMW-1:0]   qm_q   [1:NUMW];
  logic [DENW-1:0]   den_q  [1:NUMW];
  logic [SIDE_W-1:0] side_q [1:NUMW];

  for (genvar k = 1; k <= NUMW; k++) begin : g_stage
    logic              v_src;
    logic [NUMW-1:0]   np_src;
    logic [NUMW-1:0]   nm_src;
    logic [RW-1:0]     rp_src;
    logic [RW-1:0]     rm_src;
    logic [NUMW-1:0]   qp_src;
    logic [NUMW-1:0]   qm_src;
    logic [DENW-1:0]   den_src;
    logic [SIDE_W-1:0] side_src;
    logic [RW-1:0]     rp_sh;
    logic [RW-1:0]     rm_sh;
    logic [RW-1:0]     den_ext;
    logic              take_p;
    logic              take_m;

    if (k == 1) begin : g_first
      assign v_src    = in_valid;
      assign np_src   = num_p_in;
      assign nm_src   = num_m_in;
      assign rp_src   = '0;
      assign rm_src   = '0;
      assign qp_src   = '0;
      assign qm_src   = '0;
      assign den_src  = den_in;
      assign side_src = side_in;
    end else begin : g_rest
      assign v_src    = vld_q[k-1];
      assign np_src   = np_q[k-1];
      assign nm_src   = nm_q[k-1];
      assign rp_src   = rp_q[k-1];
      assign rm_src   = rm_q[k-1];
      assign qp_src   = qp_q[k-1];
      assign qm_src   = qm_q[k-1];
      assign den_src  = den_q[k-1];
      assign side_src = side_q[k-1];
    end

    assign den_ext = {1'b0, den_src};
    assign rp_sh   = {rp_src[RW-2:0], np_src[NUMW-1]};
    assign rm_sh   = {rm_src[RW-2:0], nm_src[NUMW-1]};
    assign take_p  = rp_sh >= den_ext;
    assign take_m  = rm_sh >= den_ext;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        np_q[k]   <= np_src << 1;
        nm_q[k]   <= nm_src << 1;
        rp_q[k]   <= take_p ? rp_sh - den_ext : rp_sh;
        rm_q[k]   <= take_m ? rm_sh - den_ext : rm_sh;
        qp_q[k]   <= {qp_src[NUMW-2:0], take_p};
        qm_q[k]   <= {qm_src[NUMW-2:0], take_m};
        den_q[k]  <= den_src;
        side_q[k] <= side_src;
      end
    end
  end

  assign out_valid = vld_q[NUMW];
  assign quo_p_out = qp_q[NUMW];
  assign quo_m_out = qm_q[NUMW];
  assign side_out  = side_q[NUMW];

endmodule
`default_nettype wire

// ----- hw/rtl/quadratic_root_solver.sv -----
// Throughput: one transaction per cycle unless a stalled result holds the pipeline;
// set by a fully pipelined square root (one root bit per stage) and a pipelined
// divider (one quotient bit per stage).
// A stalled result freezes the whole pipeline in place.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic signed [COEF_WIDTH-1:0] coef_a,
  input  wire logic signed [COEF_WIDTH-1:0] coef_b,
  input  wire logic signed [COEF_WIDTH-1:0] coef_c,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic signed [OUT_WIDTH-1:0]       root_plus,
  output logic signed [OUT_WIDTH-1:0]       root_minus,
  output logic [1:0]                        status
);

  localparam int CW     = COEF_WIDTH;
  localparam int NW     = 2 * CW + 2 + 2 * FRAC_BITS;
  localparam int SW     = NW / 2;
  localparam int NUMW   = CW + FRAC_BITS + 2;
  localparam int DENW   = CW + 1;
  localparam int SSIDE  = 2 + 2 * CW;
  localparam int DSIDE  = 4;
  localparam int WW     = NUMW + OUT_WIDTH + 1;

  logic en;

  logic                 d_valid;
  logic [2*CW:0]        d_val;
  status_t              d_status;
  logic signed [CW-1:0] d_a;
  logic signed [CW-1:0] d_b;

  logic [NW-1:0]        rad;
  logic                 s_valid;
  logic [SW-1:0]        s_root;
  logic [SSIDE-1:0]     s_side;
  status_t              s_status;
  logic signed [CW-1:0] s_a;
  logic signed [CW-1:0] s_b;

  logic signed [NUMW:0] base;
  logic signed [NUMW:0] s_ext;
  logic signed [NUMW:0] num_p;
  logic signed [NUMW:0] num_m;
  logic signed [NUMW:0] abs_p;
  logic signed [NUMW:0] abs_m;
  logic signed [CW:0]   two_a;
  logic signed [CW:0]   abs_two_a;

  logic                 p_valid;
  logic [NUMW-1:0]      p_num_p;
  logic [NUMW-1:0]      p_num_m;
  logic [DENW-1:0]      p_den;
  logic [DSIDE-1:0]     p_side;

  logic                 q_valid;
  logic [NUMW-1:0]      q_p;
  logic [NUMW-1:0]      q_m;
  logic [DSIDE-1:0]     q_side;
  status_t              q_status;

  function automatic logic signed [OUT_WIDTH-1:0] sat_root(
    input logic [NUMW-1:0] q,
    input logic            neg
  );
    logic signed [WW-1:0] v;
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    v  = neg ? -$signed(WW'(q)) : $signed(WW'(q));
    hi = $signed(WW'({1'b0, {(OUT_WIDTH-1){1'b1}}}));
    lo = -hi - WW'(1);
    if (v > hi) begin
      return hi[OUT_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[OUT_WIDTH-1:0];
    end
    return v[OUT_WIDTH-1:0];
  endfunction

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  qrs_disc #(.CW(CW)) u_disc (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (item_valid),
    .a_in       (coef_a),
    .b_in       (coef_b),
    .c_in       (coef_c),
    .out_valid  (d_valid),
    .d_out      (d_val),
    .status_out (d_status),
    .a_out      (d_a),
    .b_out      (d_b)
  );

  assign rad = NW'(d_val) << (2 * FRAC_BITS);

  qrs_sqrt #(.NW(NW), .SIDE_W(SSIDE)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .rad_in    (rad),
    .side_in   ({d_status, d_a, d_b}),
    .out_valid (s_valid),
    .root_out  (s_root),
    .side_out  (s_side)
  );

  assign s_status = status_t'(s_side[SSIDE-1 -: 2]);
  assign s_a      = s_side[2*CW-1:CW];
  assign s_b      = s_side[CW-1:0];

  // numerators -b*2^F +/- s, split into magnitude and quotient sign
  assign base      = -((NUMW + 1)'(s_b) <<< FRAC_BITS);
  assign s_ext     = $signed((NUMW + 1)'(s_root));
  assign num_p     = base + s_ext;
  assign num_m     = base - s_ext;
  assign abs_p     = num_p[NUMW] ? -num_p : num_p;
  assign abs_m     = num_m[NUMW] ? -num_m : num_m;
  assign two_a     = (CW + 1)'(s_a) <<< 1;
  assign abs_two_a = two_a[CW] ? -two_a : two_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num_p <= abs_p[NUMW-1:0];
      p_num_m <= abs_m[NUMW-1:0];
      p_den   <= abs_two_a;
      p_side  <= {s_status, num_p[NUMW] ^ s_a[CW-1], num_m[NUMW] ^ s_a[CW-1]};
    end
  end

  qrs_div #(.NUMW(NUMW), .DENW(DENW), .SIDE_W(DSIDE)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .num_p_in  (p_num_p),
    .num_m_in  (p_num_m),
    .den_in    (p_den),
    .side_in   (p_side),
    .out_valid (q_valid),
    .quo_p_out (q_p),
    .quo_m_out (q_m),
    .side_out  (q_side)
  );

  assign q_status = status_t'(q_side[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= q_status;
      if (q_status == STATUS_REAL) begin
        root_plus  <= sat_root(q_p, q_side[1]);
        root_minus <= sat_root(q_m, q_side[0]);
      end else begin
        root_plus  <= '0;
        root_minus <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/quadratic_root_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module quadratic_root_checker import qrs_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  input  wire logic                     item_stall,
  input  wire logic signed [15:0]       coef_a,
  input  wire logic signed [15:0]       coef_b,
  input  wire logic signed [15:0]       coef_c,
  input  wire logic                     result_valid,
  input  wire logic                     result_stall,
  input  wire logic signed [OUT_WIDTH-1:0] root_plus,
  input  wire logic signed [OUT_WIDTH-1:0] root_minus,
  input  wire logic [1:0]               status,
  output int                            fail_count,
  output int                            roots_pending
);

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] rp;
    logic signed [OUT_WIDTH-1:0] rm;
    status_t                     st;
  } roots_t;

  roots_t expected_roots[$];

  function automatic logic [63:0] isqrt_q16(logic [63:0] disc);
    logic [127:0] n;
    logic [127:0] t;
    logic [63:0]  r;
    n = {32'd0, disc, 32'd0};
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = {64'd0, r | (64'd1 << i)};
      if (t * t <= n) r = t[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] clamp_root(longint v);
    if (v > 64'sd4294967295) return 33'sh0_FFFF_FFFF;
    if (v < -64'sd4294967296) return 33'sh1_0000_0000;
    return v[OUT_WIDTH-1:0];
  endfunction

  function automatic roots_t solve_quadratic(logic signed [15:0] a, logic signed [15:0] b,
                                             logic signed [15:0] c);
    roots_t res;
    longint disc, base, den, s;
    res = '0;
    if (a == 0) begin
      res.st = STATUS_DEGEN;
      return res;
    end
    disc = longint'(b) * longint'(b) - ((longint'(a) * longint'(c)) <<< 2);
    if (disc < 0) begin
      res.st = STATUS_COMPLEX;
      return res;
    end
    s = longint'(isqrt_q16(disc));
    base = -(longint'(b) <<< 16);
    den = longint'(a) <<< 1;
    // SV division truncates toward zero
    res.rp = clamp_root((base + s) / den);
    res.rm = clamp_root((base - s) / den);
    res.st = STATUS_REAL;
    return res;
  endfunction

  assign roots_pending = expected_roots.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    roots_t e;
    if (!rst) begin
      if (item_valid && !item_stall)
        expected_roots.push_back(solve_quadratic(coef_a, coef_b, coef_c));
      if (result_valid && !result_stall) begin
        if (expected_roots.size() == 0) begin
          $error("result with no transaction pending");
          fail_count++;
        end else begin
          e = expected_roots.pop_front();
          if (root_plus !== e.rp) begin
            $error("root_plus expected %0d actual %0d", e.rp, root_plus);
            fail_count++;
          end
          if (root_minus !== e.rm) begin
            $error("root_minus expected %0d actual %0d", e.rm, root_minus);
            fail_count++;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            fail_count++;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/quadratic_root_solver_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module quadratic_root_solver_tb import qrs_pkg::*;;

  localparam int LATENCY   = 71;
  localparam int N_RANDOM  = 1900;
  localparam int MAX_CYCLE = 200000;

  logic clk, rst;
  logic item_valid, item_stall, result_valid, result_stall;
  logic signed [15:0] coef_a, coef_b, coef_c;
  logic signed [OUT_WIDTH-1:0] root_plus, root_minus;
  logic [1:0] status;
  int fail_count, roots_pending;
  int cycle;

  quadratic_root_solver u_dut (.*);

  quadratic_root_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle > MAX_CYCLE) begin
        $display("quadratic_root_solver regression: fail");
        $finish;
      end
    end
  end

  // result-side backpressure
  initial begin
    int hold;
    result_stall = 1'b1;
    @(posedge clk iff !rst);
    forever begin
      hold = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk iff result_valid);
    end
  end

  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    @(posedge clk iff !item_stall);
  endtask

  function automatic logic signed [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($signed($urandom_range(0, 16)) - 8);
      3: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] a, b, c, r1, r2;
    bit burst;
    rst = 1'b1;
    item_valid = 1'b0;
    coef_a = '0;
    coef_b = '0;
    coef_c = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_coefs(0, 5, 3, 0);
    send_coefs(0, 0, 0, 0);
    send_coefs(1, 0, 1, 0);
    send_coefs(1, 0, 0, 0);
    send_coefs(1, -3, 2, 0);
    send_coefs(1, 2, 1, 0);
    send_coefs(-1, 0, 4, 0);
    send_coefs(16'sh8000, 16'sh8000, 16'sh7FFF, 0);
    send_coefs(16'sh8000, 16'sh7FFF, 16'sh8000, 0);
    send_coefs(16'sh7FFF, 16'sh8000, 16'sh8000, 0);
    send_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
    send_coefs(1, 16'sh8000, 16'sh8000, 0);
    send_coefs(1, 16'sh7FFF, 16'sh7FFF, 0);
    send_coefs(-1, 16'sh8000, 16'sh7FFF, 0);
    send_coefs(16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_coefs(2, 0, -2, 0);
    send_coefs(-1, -1, -1, 0);
    send_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      burst = (i % 200) < 40;
      if ($urandom_range(0, 3) == 0) begin
        // build from integer roots so D is a perfect square
        r1 = 16'($signed($urandom_range(0, 200)) - 100);
        r2 = 16'($signed($urandom_range(0, 200)) - 100);
        a = 16'($signed($urandom_range(1, 3)));
        send_coefs(a, -a * (r1 + r2), a * r1 * r2, burst);
      end else begin
        send_coefs(pick_coef(), pick_coef(), pick_coef(), burst);
      end
    end
    item_valid <= 1'b0;
    wait (roots_pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && roots_pending == 0)
      $display("quadratic_root_solver regression: pass");
    else
      $display("quadratic_root_solver regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
